// ===== design/b64led_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the base64 alphabet decoder for the LED matrix loader.
package b64led_pkg;

  localparam int ROWS_DEF        = 16;
  localparam int PANELS_DEF      = 4;
  localparam int FRAME_BYTES_DEF = 256;

  localparam int          WORD_BITS    = 16;
  localparam logic [15:0] PATTERN_WORD = 16'h5050;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KIND_SHIFT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_STATUS,
    ST_FETCH,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic init_wr;
    logic in_ready;
    logic status_push;
    logic fetch;
    logic shift_push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic req_valid;
    logic req_scan;
    logic req_newline;
    logic out_free;
    logic bit_last;
    logic panel_last;
  } ctrl_sts_t;

  // Returns {valid, sextet} for one character of the standard alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ===== design/b64led_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences init, line status and row scans.
module b64led_ctrl import b64led_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (sts_i.req_valid && sts_i.req_scan) begin
          state_d = ST_FETCH;
        end else if (sts_i.req_valid && sts_i.req_newline) begin
          state_d = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_FETCH: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts_i.out_free && sts_i.bit_last) begin
          state_d = sts_i.panel_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_INIT:   cmd_o.init_wr     = 1'b1;
      ST_IDLE:   cmd_o.in_ready    = 1'b1;
      ST_STATUS: cmd_o.status_push = sts_i.out_free;
      ST_FETCH:  cmd_o.fetch       = 1'b1;
      ST_SHIFT:  cmd_o.shift_push  = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== design/b64led_dp.sv =====
`timescale 1ns / 1ps
// Datapath: base64 decoder, two-bank frame memory, row shifter and output register.
module b64led_dp import b64led_pkg::*; #(
  parameter int ROWS        = ROWS_DEF,
  parameter int PANELS      = PANELS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_sts_t  sts_o,
  input  logic       s_tvalid_i,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tuser_i,
  input  logic       m_tready_i,
  output logic       m_tvalid_o,
  output logic [7:0] m_tdata_o,
  output logic       m_tuser_o,
  output logic       m_tlast_o
);

  localparam int BANK_WORDS = FRAME_BYTES / 2;
  localparam int AW         = $clog2(BANK_WORDS);
  localparam int NEED_CHARS = (FRAME_BYTES / 3) * 4 +
                              (((FRAME_BYTES % 3) != 0) ? (FRAME_BYTES % 3) + 1 : 0);
  localparam int COUNT_CAP  = NEED_CHARS + 1;
  localparam int CW         = $clog2(COUNT_CAP + 1);
  localparam int RW         = $clog2(ROWS);
  localparam int PSW        = (PANELS > 1) ? $clog2(PANELS) : 1;
  localparam int SPAN_W     = $clog2(2 * PANELS * ROWS + 1);
  localparam int SAW        = ((SPAN_W > AW) ? SPAN_W : AW) + 1;
  localparam int CMPV       = ((BANK_WORDS / ROWS) > 2 * PANELS) ? (BANK_WORDS / ROWS)
                                                                 : 2 * PANELS;
  localparam int CMPW       = $clog2(CMPV + 1);

  // Frame memory, split into byte lanes.
  logic [7:0] mem_lo [2][BANK_WORDS];
  logic [7:0] mem_hi [2][BANK_WORDS];

  // Init sweep.
  logic            init_bank_q, init_bank_d;
  logic [AW-1:0]   init_w_q, init_w_d;
  logic [RW-1:0]   pr_q, pr_d;
  logic [CMPW-1:0] pm_q, pm_d;
  logic [CMPW-1:0] pw_q, pw_d;
  logic [15:0]     init_word;

  // Decoder.
  logic          shown_q, shown_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] bidx_q, bidx_d;
  logic          prefix_q, prefix_d;
  logic [5:0]    acc_q, acc_d;
  logic [1:0]    phase_q, phase_d;
  logic          ok_q, ok_d;
  logic [6:0]    sx;
  logic          accept, is_cr, is_nl, take;
  logic          put_en;
  logic [7:0]    put_val;

  // Write port.
  logic          we_lo, we_hi, wbank;
  logic [AW-1:0] waddr;
  logic [7:0]    wd_lo, wd_hi;

  // Scan.
  logic [RW-1:0]  row_q, row_d;
  logic [PSW-1:0] pslot_q, pslot_d;
  logic [3:0]     bit_q, bit_d;
  logic [SAW-1:0] ev_idx, od_idx;
  logic           ev_oob, od_oob;
  logic [AW-1:0]  ea, oa;
  logic [15:0]    rd_ev_q, rd_od_q;
  logic           ev_oob_q, od_oob_q;
  logic [RW+3:0]  row_ext, bit_ext;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q;
  logic       out_user_q, out_last_q;
  logic       out_free;

  assign accept = cmd_i.in_ready && s_tvalid_i;
  assign is_cr  = (s_tdata_i == CHAR_CR);
  assign is_nl  = (s_tdata_i == CHAR_LF);
  assign take   = accept && (s_tuser_i == MODE_BYTE) && !is_cr && !is_nl;
  assign sx     = sextet_of(s_tdata_i);

  always_comb begin
    shown_d  = shown_q;
    count_d  = count_q;
    bidx_d   = bidx_q;
    prefix_d = prefix_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    ok_d     = ok_q;
    put_en   = 1'b0;
    put_val  = '0;
    if (take && !prefix_q) begin
      if (!sx[6]) begin
        prefix_d = 1'b1;
      end else if (count_q < CW'(COUNT_CAP)) begin
        case (phase_q)
          2'd0: begin
            acc_d = sx[5:0];
          end
          2'd1: begin
            put_en  = 1'b1;
            put_val = {acc_q[5:0], sx[5:4]};
            acc_d   = {2'b00, sx[3:0]};
          end
          2'd2: begin
            put_en  = 1'b1;
            put_val = {acc_q[3:0], sx[5:2]};
            acc_d   = {4'b0000, sx[1:0]};
          end
          default: begin
            put_en  = 1'b1;
            put_val = {acc_q[1:0], sx[5:0]};
            acc_d   = '0;
          end
        endcase
        phase_d = phase_q + 2'd1;
        count_d = count_q + CW'(1);
        if (put_en) bidx_d = bidx_q + CW'(1);
      end
    end else if (accept && (s_tuser_i == MODE_BYTE) && is_nl) begin
      ok_d     = (count_q == CW'(NEED_CHARS));
      shown_d  = shown_q ^ ok_d;
      count_d  = '0;
      bidx_d   = '0;
      prefix_d = 1'b0;
      acc_d    = '0;
      phase_d  = '0;
    end
  end

  // Init sweep: bank zero gets the diagonal test pattern, bank one zeros.
  always_comb begin
    init_bank_d = init_bank_q;
    init_w_d    = init_w_q;
    pr_d        = pr_q;
    pm_d        = pm_q;
    pw_d        = pw_q;
    if (cmd_i.init_wr) begin
      if (init_w_q == AW'(BANK_WORDS - 1)) begin
        init_w_d    = '0;
        init_bank_d = 1'b1;
      end else begin
        init_w_d = init_w_q + AW'(1);
      end
      if (pr_q == RW'(ROWS - 1)) begin
        pr_d = '0;
        pm_d = '0;
        pw_d = pw_q + CMPW'(1);
      end else begin
        pr_d = pr_q + RW'(1);
        pm_d = (pm_q == CMPW'(2 * PANELS - 1)) ? '0 : pm_q + CMPW'(1);
      end
    end
  end

  assign init_word = (!init_bank_q && (pw_q == pm_q)) ? PATTERN_WORD : 16'h0000;

  always_comb begin
    if (cmd_i.init_wr) begin
      we_lo = 1'b1;
      we_hi = 1'b1;
      wbank = init_bank_q;
      waddr = init_w_q;
      wd_lo = init_word[7:0];
      wd_hi = init_word[15:8];
    end else begin
      we_lo = put_en && (bidx_q[CW-1:1] < (CW-1)'(BANK_WORDS)) && !bidx_q[0];
      we_hi = put_en && (bidx_q[CW-1:1] < (CW-1)'(BANK_WORDS)) && bidx_q[0];
      wbank = ~shown_q;
      waddr = bidx_q[AW:1];
      wd_lo = put_val;
      wd_hi = put_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_lo) mem_lo[wbank][waddr] <= wd_lo;
    if (we_hi) mem_hi[wbank][waddr] <= wd_hi;
  end

  // Word addresses for the current panel of the current row.
  assign ev_idx = SAW'(pslot_q) * SAW'(2 * ROWS) + SAW'(row_q);
  assign od_idx = ev_idx + SAW'(ROWS);
  assign ev_oob = (ev_idx >= SAW'(BANK_WORDS));
  assign od_oob = (od_idx >= SAW'(BANK_WORDS));
  assign ea     = ev_oob ? '0 : ev_idx[AW-1:0];
  assign oa     = od_oob ? '0 : od_idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      rd_ev_q  <= {mem_hi[shown_q][ea], mem_lo[shown_q][ea]};
      rd_od_q  <= {mem_hi[shown_q][oa], mem_lo[shown_q][oa]};
      ev_oob_q <= ev_oob;
      od_oob_q <= od_oob;
    end
  end

  always_comb begin
    row_d   = row_q;
    pslot_d = pslot_q;
    bit_d   = bit_q;
    if (accept && (s_tuser_i == MODE_TICK)) begin
      pslot_d = PSW'(PANELS - 1);
      bit_d   = '0;
    end else if (cmd_i.shift_push) begin
      bit_d = bit_q + 4'd1;
      if (bit_q == 4'(WORD_BITS - 1)) begin
        if (pslot_q != '0) begin
          pslot_d = pslot_q - PSW'(1);
        end else begin
          row_d = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);
        end
      end
    end
  end

  assign row_ext  = {4'b0000, row_q};
  assign bit_ext  = {{RW{1'b0}}, bit_q};
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.status_push || cmd_i.shift_push) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.status_push) begin
      out_data_q <= {ok_q, 7'b0000000};
      out_user_q <= KIND_STATUS;
      out_last_q <= 1'b0;
    end else if (cmd_i.shift_push) begin
      out_data_q <= {1'b0,
                     rd_od_q[bit_q] && !od_oob_q,
                     rd_ev_q[bit_q] && !ev_oob_q,
                     bit_ext == row_ext,
                     row_ext[3:0]};
      out_user_q <= KIND_SHIFT;
      out_last_q <= (pslot_q == '0) && (bit_q == 4'(WORD_BITS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_bank_q <= 1'b0;
      init_w_q    <= '0;
      pr_q        <= '0;
      pm_q        <= '0;
      pw_q        <= '0;
      shown_q     <= 1'b0;
      count_q     <= '0;
      bidx_q      <= '0;
      prefix_q    <= 1'b0;
      acc_q       <= '0;
      phase_q     <= '0;
      ok_q        <= 1'b0;
      row_q       <= '0;
      pslot_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      init_bank_q <= init_bank_d;
      init_w_q    <= init_w_d;
      pr_q        <= pr_d;
      pm_q        <= pm_d;
      pw_q        <= pw_d;
      shown_q     <= shown_d;
      count_q     <= count_d;
      bidx_q      <= bidx_d;
      prefix_q    <= prefix_d;
      acc_q       <= acc_d;
      phase_q     <= phase_d;
      ok_q        <= ok_d;
      row_q       <= row_d;
      pslot_q     <= pslot_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.init_last   = cmd_i.init_wr && init_bank_q &&
                             (init_w_q == AW'(BANK_WORDS - 1));
  assign sts_o.req_valid   = s_tvalid_i;
  assign sts_o.req_scan    = (s_tuser_i == MODE_TICK);
  assign sts_o.req_newline = (s_tuser_i == MODE_BYTE) && is_nl;
  assign sts_o.out_free    = out_free;
  assign sts_o.bit_last    = (bit_q == 4'(WORD_BITS - 1));
  assign sts_o.panel_last  = (pslot_q == '0);

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== design/base64_frame_loader_led_matrix_scan.sv =====
`timescale 1ns / 1ps
// Top level of the base64 frame loader and multiplexed LED matrix scan driver.
// After reset the block writes the diagonal test pattern and the empty second bank
// into the frame memory, and accepts no request during that time. A received byte
// is taken while the block is idle; a newline is followed by its status result. A scan
// tick is accepted, then for each panel the block does one frame memory read of its
// even and odd word and gives sixteen shift results, one per cycle while the output
// side keeps up. Lines are decoded into the hidden bank as characters arrive and
// swapped in on a newline that ends a line of the full length.
module base64_frame_loader_led_matrix_scan import b64led_pkg::*; #(
  parameter int ROWS        = ROWS_DEF,
  parameter int PANELS      = PANELS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
  input  logic       s_axis_tuser,  // [0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [3:0] row, [4] row_select_bit, [5] data_even,
                                    // [6] data_odd, [7] frame_loaded
  output logic       m_axis_tuser,  // [0] kind
  output logic       m_axis_tlast
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  b64led_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  b64led_dp #(
    .ROWS        (ROWS),
    .PANELS      (PANELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule
